// ===== rtl/rmbf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbf_pkg
// Shared types and constants of the repeated median Bragg curve fit.
// ----------------------------------------------------------------------------
package rmbf_pkg;

  localparam int unsigned MaxHits    = 64;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned DivW       = 72;
  localparam int unsigned FitW       = 48;

  typedef struct packed {
    logic [31:0] coordinate;
    logic [31:0] energy_rate;
    logic        last_hit;
  } hit_t;

  typedef struct packed {
    logic                   fit_valid;
    logic signed [FitW-1:0] gradient;
    logic signed [FitW-1:0] intercept;
    logic                   hits_dropped;
  } result_t;

  typedef enum logic [4:0] {
    StIdle,
    StXRead,
    StXDiff,
    StXSel,
    StXDiv,
    StXSqrt,
    StXNext,
    StPRead,
    StPLoad,
    StJRead,
    StJLoad,
    StMul,
    StDStart,
    StDWait,
    StJNext,
    StPNext,
    StMRead,
    StMLoadA,
    StMReadB,
    StMCmpB,
    StMPick,
    StMFin,
    StDone
  } back_state_e;

endpackage

// ===== rtl/rmbf_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbf_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module rmbf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/rmbf_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbf_div
// Restoring divider, one quotient bit per cycle, wide dividend by 32 bits.
// ----------------------------------------------------------------------------
module rmbf_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [rmbf_pkg::DivW-1:0]    dividend_i,
  input  logic [31:0]                  divisor_i,
  output logic                         done_o,
  output logic [rmbf_pkg::DivW-1:0]    quotient_o
);

  localparam int unsigned CntW = $clog2(rmbf_pkg::DivW + 1);

  logic                      run_q;
  logic                      done_q;
  logic [CntW-1:0]           cnt_q;
  logic [31:0]               rem_q;
  logic [31:0]               dvs_q;
  logic [rmbf_pkg::DivW-1:0] quo_q;
  logic [32:0]               shifted;
  logic                      fits;
  logic [32:0]               diff;

  assign shifted = {rem_q, quo_q[rmbf_pkg::DivW-1]};
  assign fits    = shifted >= {1'b0, dvs_q};
  assign diff    = shifted - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CntW'(rmbf_pkg::DivW);
      end else if (run_q) begin
        cnt_q <= cnt_q - CntW'(1);
        if (cnt_q == CntW'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= fits ? diff[31:0] : shifted[31:0];
      quo_q <= {quo_q[rmbf_pkg::DivW-2:0], fits};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== rtl/rmbf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbf_front
// Hit intake: accepts hits and queues them for the fitting engine.
// ----------------------------------------------------------------------------
module rmbf_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rmbf_pkg::hit_t hit_i,
  output logic           busy_o,
  input  logic           pop_i,
  output logic           avail_o,
  output rmbf_pkg::hit_t hit_o
);

  localparam int unsigned Depth = rmbf_pkg::QueueDepth;
  localparam int unsigned PW    = $clog2(Depth);
  localparam int unsigned FW    = $clog2(Depth + 1);

  rmbf_pkg::hit_t mem_q [Depth];
  logic [PW-1:0]  wptr_q;
  logic [PW-1:0]  rptr_q;
  logic [FW-1:0]  fill_q;
  logic           push;
  logic           pop;

  assign busy_o  = fill_q == FW'(Depth);
  assign avail_o = fill_q != '0;
  assign push    = start_i && !busy_o;
  assign pop     = pop_i && avail_o;
  assign hit_o   = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wptr_q <= wptr_q + PW'(1);
      end
      if (pop) begin
        rptr_q <= rptr_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + FW'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - FW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wptr_q] <= hit_i;
    end
  end

endmodule

// ===== rtl/rmbf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rmbf_back
// Fitting engine: stores hits, transforms x, runs pair divisions and medians.
// ----------------------------------------------------------------------------
module rmbf_back #(
  parameter int unsigned MAX_HITS = rmbf_pkg::MaxHits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              hit_valid_i,
  input  rmbf_pkg::hit_t    hit_i,
  output logic              hit_pop_o,
  output logic              done_o,
  output rmbf_pkg::result_t result_o
);

  localparam int unsigned AW = $clog2(MAX_HITS);
  localparam int unsigned CW = $clog2(MAX_HITS + 1);
  localparam int unsigned FW = rmbf_pkg::FitW;
  localparam int unsigned DW = rmbf_pkg::DivW;

  function automatic logic [FW-1:0] sat_fit(input logic neg, input logic [DW-1:0] q);
    logic [DW-1:0] lim;
    logic [FW-1:0] res;
    lim = DW'(1) << (FW - 1);
    if (neg) begin
      res = (q > lim) ? {1'b1, {(FW-1){1'b0}}} : (~q[FW-1:0] + FW'(1));
    end else begin
      res = (q > lim - DW'(1)) ? {1'b0, {(FW-1){1'b1}}} : q[FW-1:0];
    end
    return res;
  endfunction

  rmbf_pkg::back_state_e state_q, state_d;

  logic [CW-1:0]     cnt_q, i_q, j_q, k_q, m_q, a_q, b_q, mk_q;
  logic [31:0]       largest_q, d_q, c_q, xi_q, yi_q, xj_q, yj_q;
  logic [DW-1:0]     lim_q;
  logic [4:0]        bit_q;
  logic [63:0]       pa_q, pb_q;
  logic              neg_s_q, neg_i_q, ovf_q, final_q;
  logic [CW-1:0]     lt_s_q, eq_s_q, lt_i_q, eq_i_q;
  logic [FW-1:0]     va_s_q, va_i_q, lo_s_q, hi_s_q, lo_i_q, hi_i_q;
  rmbf_pkg::result_t res_q;

  logic          store;
  logic          co_we, xr_we, pr_we, md_we;
  logic [AW-1:0] hit_ra, m_ra;
  logic [31:0]   co_rd, ra_rd;
  logic [32:0]   xr_rd, xr_wd;
  logic [FW-1:0] ps_rd, pi_rd, sm_rd, im_rd, ms_rd, mi_rd, ps_wd, pi_wd;
  logic [31:0]   cand, c_new, dxm, dym;
  logic [63:0]   sq, mag;
  logic          take, skip, dneg, yneg, ineg;
  logic          div0_start, div1_start, div0_done, div1_done;
  logic [DW-1:0] div0_dvd, div1_dvd, div0_q, div1_q;
  logic [31:0]   div0_dvs;
  logic [CW-1:0] p1, p2;
  logic [FW:0]   avg_s, avg_i;
  logic          i_last, j_last, b_last, a_last;

  assign store  = cnt_q < CW'(MAX_HITS);
  assign i_last = (i_q + CW'(1)) == cnt_q;
  assign j_last = (j_q + CW'(1)) == cnt_q;
  assign b_last = (b_q + CW'(1)) == mk_q;
  assign a_last = (a_q + CW'(1)) == mk_q;

  assign cand  = c_q | (32'd1 << bit_q);
  assign sq    = cand * cand;
  assign take  = {8'd0, sq} <= lim_q;
  assign c_new = take ? cand : c_q;

  assign skip = (j_q == i_q) || !xr_rd[32] || (xr_rd[31:0] == xi_q);
  assign dneg = xj_q < xi_q;
  assign dxm  = dneg ? (xi_q - xj_q) : (xj_q - xi_q);
  assign yneg = yj_q < yi_q;
  assign dym  = yneg ? (yi_q - yj_q) : (yj_q - yi_q);
  assign ineg = pa_q < pb_q;
  assign mag  = ineg ? (pb_q - pa_q) : (pa_q - pb_q);

  assign ms_rd = final_q ? sm_rd : ps_rd;
  assign mi_rd = final_q ? im_rd : pi_rd;
  assign p1    = (mk_q - CW'(1)) >> 1;
  assign p2    = mk_q >> 1;
  assign avg_s = ({lo_s_q[FW-1], lo_s_q} + {hi_s_q[FW-1], hi_s_q}) >> 1;
  assign avg_i = ({lo_i_q[FW-1], lo_i_q} + {hi_i_q[FW-1], hi_i_q}) >> 1;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rmbf_pkg::StIdle:   if (hit_valid_i && hit_i.last_hit) state_d = rmbf_pkg::StXRead;
      rmbf_pkg::StXRead:  state_d = rmbf_pkg::StXDiff;
      rmbf_pkg::StXDiff:  state_d = rmbf_pkg::StXSel;
      rmbf_pkg::StXSel:   state_d = (d_q > 32'd1) ? rmbf_pkg::StXDiv : rmbf_pkg::StXNext;
      rmbf_pkg::StXDiv:   if (div0_done) state_d = rmbf_pkg::StXSqrt;
      rmbf_pkg::StXSqrt:  if (bit_q == 5'd0) state_d = rmbf_pkg::StXNext;
      rmbf_pkg::StXNext:  state_d = i_last ? rmbf_pkg::StPRead : rmbf_pkg::StXRead;
      rmbf_pkg::StPRead:  state_d = rmbf_pkg::StPLoad;
      rmbf_pkg::StPLoad:  state_d = xr_rd[32] ? rmbf_pkg::StJRead : rmbf_pkg::StPNext;
      rmbf_pkg::StJRead:  state_d = rmbf_pkg::StJLoad;
      rmbf_pkg::StJLoad:  state_d = skip ? rmbf_pkg::StJNext : rmbf_pkg::StMul;
      rmbf_pkg::StMul:    state_d = rmbf_pkg::StDStart;
      rmbf_pkg::StDStart: state_d = rmbf_pkg::StDWait;
      rmbf_pkg::StDWait:  if (div0_done) state_d = rmbf_pkg::StJNext;
      rmbf_pkg::StJNext: begin
        if (!j_last) state_d = rmbf_pkg::StJRead;
        else if (k_q == '0) state_d = rmbf_pkg::StPNext;
        else state_d = rmbf_pkg::StMRead;
      end
      rmbf_pkg::StPNext: begin
        if (!i_last) state_d = rmbf_pkg::StPRead;
        else if (m_q == '0) state_d = rmbf_pkg::StDone;
        else state_d = rmbf_pkg::StMRead;
      end
      rmbf_pkg::StMRead:  state_d = rmbf_pkg::StMLoadA;
      rmbf_pkg::StMLoadA: state_d = rmbf_pkg::StMReadB;
      rmbf_pkg::StMReadB: state_d = rmbf_pkg::StMCmpB;
      rmbf_pkg::StMCmpB:  state_d = b_last ? rmbf_pkg::StMPick : rmbf_pkg::StMReadB;
      rmbf_pkg::StMPick:  state_d = a_last ? rmbf_pkg::StMFin : rmbf_pkg::StMRead;
      rmbf_pkg::StMFin:   state_d = final_q ? rmbf_pkg::StDone : rmbf_pkg::StPNext;
      rmbf_pkg::StDone:   state_d = rmbf_pkg::StIdle;
      default:            state_d = rmbf_pkg::StIdle;
    endcase
  end

  always_comb begin
    hit_pop_o  = (state_q == rmbf_pkg::StIdle) && hit_valid_i;
    co_we      = hit_pop_o && store;
    hit_ra     = (state_q == rmbf_pkg::StJRead) ? j_q[AW-1:0] : i_q[AW-1:0];
    m_ra       = (state_q == rmbf_pkg::StMReadB) ? b_q[AW-1:0] : a_q[AW-1:0];
    xr_we      = ((state_q == rmbf_pkg::StXSel) && (d_q <= 32'd1))
                 || ((state_q == rmbf_pkg::StXSqrt) && (bit_q == 5'd0));
    if (state_q == rmbf_pkg::StXSqrt) begin
      xr_wd = {1'b1, c_new};
    end else if (d_q == 32'd0) begin
      xr_wd = '0;
    end else begin
      xr_wd = {1'b1, 32'hFFFF_FFFF};
    end
    pr_we      = (state_q == rmbf_pkg::StDWait) && div0_done;
    ps_wd      = sat_fit(neg_s_q, div0_q);
    pi_wd      = sat_fit(neg_i_q, div1_q);
    md_we      = (state_q == rmbf_pkg::StMFin) && !final_q;
    div0_start = ((state_q == rmbf_pkg::StXSel) && (d_q > 32'd1))
                 || (state_q == rmbf_pkg::StDStart);
    div1_start = state_q == rmbf_pkg::StDStart;
    div0_dvd   = (state_q == rmbf_pkg::StXSel) ? (DW'(1) << 64) : {8'd0, dym, 32'd0};
    div0_dvs   = (state_q == rmbf_pkg::StXSel) ? d_q : dxm;
    div1_dvd   = {mag, 8'd0};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= rmbf_pkg::StIdle;
      cnt_q     <= '0;
      largest_q <= '0;
      ovf_q     <= 1'b0;
      final_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      if (hit_pop_o) begin
        if (store) begin
          cnt_q <= cnt_q + CW'(1);
          if (hit_i.coordinate > largest_q) largest_q <= hit_i.coordinate;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (state_q == rmbf_pkg::StJNext) final_q <= 1'b0;
      if (state_q == rmbf_pkg::StPNext && i_last) final_q <= 1'b1;
      if (state_q == rmbf_pkg::StDone) begin
        cnt_q     <= '0;
        largest_q <= '0;
        ovf_q     <= 1'b0;
        final_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      rmbf_pkg::StIdle:  i_q <= '0;
      rmbf_pkg::StXDiff: d_q <= largest_q - co_rd;
      rmbf_pkg::StXDiv: begin
        lim_q <= div0_q;
        c_q   <= '0;
        bit_q <= 5'd31;
      end
      rmbf_pkg::StXSqrt: begin
        c_q   <= c_new;
        bit_q <= bit_q - 5'd1;
      end
      rmbf_pkg::StXNext: begin
        i_q <= i_last ? '0 : i_q + CW'(1);
        m_q <= '0;
      end
      rmbf_pkg::StPLoad: begin
        xi_q <= xr_rd[31:0];
        yi_q <= ra_rd;
        j_q  <= '0;
        k_q  <= '0;
      end
      rmbf_pkg::StJLoad: begin
        xj_q <= xr_rd[31:0];
        yj_q <= ra_rd;
      end
      rmbf_pkg::StMul: begin
        pa_q <= xj_q * yi_q;
        pb_q <= xi_q * yj_q;
      end
      rmbf_pkg::StDStart: begin
        neg_s_q <= yneg ^ dneg;
        neg_i_q <= ineg ^ dneg;
      end
      rmbf_pkg::StDWait: if (div0_done) k_q <= k_q + CW'(1);
      rmbf_pkg::StJNext: begin
        j_q  <= j_q + CW'(1);
        mk_q <= k_q;
        a_q  <= '0;
      end
      rmbf_pkg::StPNext: begin
        if (i_last) begin
          mk_q  <= m_q;
          a_q   <= '0;
          res_q <= '{fit_valid: 1'b0, gradient: '0, intercept: '0, hits_dropped: ovf_q};
        end else begin
          i_q <= i_q + CW'(1);
        end
      end
      rmbf_pkg::StMLoadA: begin
        va_s_q <= ms_rd;
        va_i_q <= mi_rd;
        b_q    <= '0;
        lt_s_q <= '0;
        eq_s_q <= '0;
        lt_i_q <= '0;
        eq_i_q <= '0;
      end
      rmbf_pkg::StMCmpB: begin
        b_q <= b_q + CW'(1);
        if ($signed(ms_rd) < $signed(va_s_q)) lt_s_q <= lt_s_q + CW'(1);
        if (ms_rd == va_s_q) eq_s_q <= eq_s_q + CW'(1);
        if ($signed(mi_rd) < $signed(va_i_q)) lt_i_q <= lt_i_q + CW'(1);
        if (mi_rd == va_i_q) eq_i_q <= eq_i_q + CW'(1);
      end
      rmbf_pkg::StMPick: begin
        a_q <= a_q + CW'(1);
        if (lt_s_q <= p1 && p1 < lt_s_q + eq_s_q) lo_s_q <= va_s_q;
        if (lt_s_q <= p2 && p2 < lt_s_q + eq_s_q) hi_s_q <= va_s_q;
        if (lt_i_q <= p1 && p1 < lt_i_q + eq_i_q) lo_i_q <= va_i_q;
        if (lt_i_q <= p2 && p2 < lt_i_q + eq_i_q) hi_i_q <= va_i_q;
      end
      rmbf_pkg::StMFin: begin
        if (final_q) begin
          res_q <= '{fit_valid: 1'b1, gradient: avg_s[FW-1:0], intercept: avg_i[FW-1:0],
                     hits_dropped: ovf_q};
        end else begin
          m_q <= m_q + CW'(1);
        end
      end
      default: ;
    endcase
  end

  rmbf_ram #(.Width(32), .Depth(MAX_HITS)) u_coords (
    .clk_i, .we_i(co_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(hit_i.coordinate),
    .raddr_i(hit_ra), .rdata_o(co_rd)
  );

  rmbf_ram #(.Width(32), .Depth(MAX_HITS)) u_rates (
    .clk_i, .we_i(co_we), .waddr_i(cnt_q[AW-1:0]), .wdata_i(hit_i.energy_rate),
    .raddr_i(hit_ra), .rdata_o(ra_rd)
  );

  rmbf_ram #(.Width(33), .Depth(MAX_HITS)) u_xs (
    .clk_i, .we_i(xr_we), .waddr_i(i_q[AW-1:0]), .wdata_i(xr_wd),
    .raddr_i(hit_ra), .rdata_o(xr_rd)
  );

  rmbf_ram #(.Width(FW), .Depth(MAX_HITS)) u_pair_slopes (
    .clk_i, .we_i(pr_we), .waddr_i(k_q[AW-1:0]), .wdata_i(ps_wd),
    .raddr_i(m_ra), .rdata_o(ps_rd)
  );

  rmbf_ram #(.Width(FW), .Depth(MAX_HITS)) u_pair_icpts (
    .clk_i, .we_i(pr_we), .waddr_i(k_q[AW-1:0]), .wdata_i(pi_wd),
    .raddr_i(m_ra), .rdata_o(pi_rd)
  );

  rmbf_ram #(.Width(FW), .Depth(MAX_HITS)) u_slope_meds (
    .clk_i, .we_i(md_we), .waddr_i(m_q[AW-1:0]), .wdata_i(avg_s[FW-1:0]),
    .raddr_i(m_ra), .rdata_o(sm_rd)
  );

  rmbf_ram #(.Width(FW), .Depth(MAX_HITS)) u_icpt_meds (
    .clk_i, .we_i(md_we), .waddr_i(m_q[AW-1:0]), .wdata_i(avg_i[FW-1:0]),
    .raddr_i(m_ra), .rdata_o(im_rd)
  );

  rmbf_div u_div_slope (
    .clk_i, .rst_ni, .start_i(div0_start), .dividend_i(div0_dvd), .divisor_i(div0_dvs),
    .done_o(div0_done), .quotient_o(div0_q)
  );

  rmbf_div u_div_icpt (
    .clk_i, .rst_ni, .start_i(div1_start), .dividend_i(div1_dvd), .divisor_i(dxm),
    .done_o(div1_done), .quotient_o(div1_q)
  );

  assign done_o   = (state_q == rmbf_pkg::StDone) && !div1_done;
  assign result_o = res_q;

endmodule

// ===== rtl/repeated_median_bragg_fit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// repeated_median_bragg_fit
// Repeated median straight-line fit of a track's Bragg curve.
// Loading: one hit per cycle through a two-entry queue; busy_o rises once two
//   hits wait while the fit runs. Fit of n hits: a divide and a 32-step inverse
//   square root per hit whose difference exceeds one, neither otherwise; a
//   multiply and two divides per usable pair, none per skipped pair; each of
//   K values compared with all K per median; then the one-cycle strobe.
// Reset: asynchronous; clears queue, counts and flags. Stores need no clearing.
// ----------------------------------------------------------------------------
module repeated_median_bragg_fit #(
  parameter int unsigned MAX_HITS = rmbf_pkg::MaxHits
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  rmbf_pkg::hit_t    hit_i,
  output logic              busy_o,
  output logic              done_o,
  output rmbf_pkg::result_t result_o
);

  logic           q_avail;
  logic           q_pop;
  rmbf_pkg::hit_t q_hit;

  rmbf_front u_front (
    .clk_i, .rst_ni, .start_i, .hit_i, .busy_o,
    .pop_i(q_pop), .avail_o(q_avail), .hit_o(q_hit)
  );

  rmbf_back #(.MAX_HITS(MAX_HITS)) u_back (
    .clk_i, .rst_ni, .hit_valid_i(q_avail), .hit_i(q_hit), .hit_pop_o(q_pop),
    .done_o, .result_o
  );

endmodule
